FILE: rtl/core/tprd_pkg.sv
package tprd_pkg;

  localparam int unsigned PacketBytes = 18;
  localparam int unsigned FingerSlots = 5;
  localparam int unsigned SlotBase    = 2;
  localparam int unsigned SlotEnd     = SlotBase + 3 * FingerSlots;

  localparam logic [7:0] HdrNormal = 8'h5D;

  typedef enum logic [1:0] {
    KindFinger  = 2'd0,
    KindNoPress = 2'd1,
    KindUnknown = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [2:0]   finger_slot;
    logic [11:0]  x_pos;
    logic [11:0]  y_pos;
    logic         last_finger;
    logic [7:0]   packet_type;
  } out_word_t;

endpackage

FILE: rtl/core/tprd_in_reg.sv
module tprd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tprd_pkg::in_word_t in_word_i,
  output logic              valid_o,
  input  logic              ready_i,
  output tprd_pkg::in_word_t word_o
);

  logic               valid_q, valid_d;
  tprd_pkg::in_word_t word_q;

  assign in_ready_o = !valid_q || ready_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q <= in_word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

FILE: rtl/core/tprd_decode.sv
module tprd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  tprd_pkg::in_word_t word_i,
  output logic               res_valid_o,
  output tprd_pkg::out_word_t res_o
);

  localparam logic [4:0] PacketLast = 5'(tprd_pkg::PacketBytes - 1);
  localparam logic [4:0] SlotLo     = 5'(tprd_pkg::SlotBase);
  localparam logic [4:0] SlotHi     = 5'(tprd_pkg::SlotEnd);

  logic [4:0] pos_q, pos_d, pos;
  logic [2:0] count_q, count_d;
  logic [4:0] mask_q, mask_d;
  logic [2:0] reported_q, reported_d;
  logic       skip_q, skip_d, skip;
  logic [2:0] slot_q, slot_d;
  logic [1:0] part_q, part_d;
  logic [7:0] sb0_q, sb1_q;
  logic       in_slots, mask_hit;
  logic [7:0] b;

  assign b        = word_i.rx_byte;
  assign pos      = word_i.packet_start ? 5'd0 : pos_q;
  assign skip     = word_i.packet_start ? 1'b0 : skip_q;
  assign in_slots = (pos >= SlotLo) && (pos < SlotHi);
  assign mask_hit = mask_q[0] & (slot_q == 3'd0) | mask_q[1] & (slot_q == 3'd1)
                  | mask_q[2] & (slot_q == 3'd2) | mask_q[3] & (slot_q == 3'd3)
                  | mask_q[4] & (slot_q == 3'd4);

  always_comb begin
    count_d     = count_q;
    mask_d      = mask_q;
    reported_d  = reported_q;
    skip_d      = skip;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.result_kind = tprd_pkg::KindFinger;
    res_o.packet_type = tprd_pkg::HdrNormal;
    if (pos == 5'd0) begin
      if (b != tprd_pkg::HdrNormal) begin
        skip_d            = 1'b1;
        res_valid_o       = 1'b1;
        res_o.result_kind = tprd_pkg::KindUnknown;
        res_o.packet_type = b;
      end else begin
        skip_d = 1'b0;
      end
    end else if (!skip) begin
      if (pos == 5'd1) begin
        count_d    = b[2:0];
        mask_d     = b[7:3];
        reported_d = 3'd0;
        if (b[2:0] == 3'd0) begin
          res_valid_o       = 1'b1;
          res_o.result_kind = tprd_pkg::KindNoPress;
        end
      end else if (in_slots && part_q == 2'd2 && count_q != 3'd0 && mask_hit) begin
        res_valid_o       = 1'b1;
        res_o.finger_slot = slot_q;
        res_o.x_pos       = {sb0_q[7:4], sb1_q};
        res_o.y_pos       = {sb0_q[3:0], b};
        res_o.last_finger = (reported_q == count_q - 3'd1);
        reported_d        = reported_q + 3'd1;
      end
    end
  end

  // slot and byte-in-slot counters follow the position
  always_comb begin
    if (pos < SlotLo) begin
      slot_d = 3'd0;
      part_d = 2'd0;
    end else if (part_q == 2'd2) begin
      slot_d = slot_q + 3'd1;
      part_d = 2'd0;
    end else begin
      slot_d = slot_q;
      part_d = part_q + 2'd1;
    end
    pos_d = (pos >= PacketLast) ? 5'd0 : pos + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 5'd0;
      count_q    <= 3'd0;
      mask_q     <= 5'd0;
      reported_q <= 3'd0;
      skip_q     <= 1'b0;
      slot_q     <= 3'd0;
      part_q     <= 2'd0;
    end else if (fire_i) begin
      pos_q      <= pos_d;
      count_q    <= count_d;
      mask_q     <= mask_d;
      reported_q <= reported_d;
      skip_q     <= skip_d;
      slot_q     <= slot_d;
      part_q     <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && !skip && in_slots && part_q == 2'd0) begin
      sb0_q <= b;
    end
    if (fire_i && !skip && in_slots && part_q == 2'd1) begin
      sb1_q <= b;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PacketLast)
    else $error("byte position past packet end");

  a_unknown_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.result_kind == tprd_pkg::KindUnknown |=> skip_q)
    else $error("unknown header did not set skip");

  a_finger_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_valid_o && res_o.result_kind == tprd_pkg::KindFinger
      |-> count_q != 3'd0 && !skip)
    else $error("finger word without a finger count");

  a_good_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && pos == 5'd0 && b == tprd_pkg::HdrNormal |=> !skip_q && pos_q == 5'd1)
    else $error("normal header not taken");

endmodule

FILE: rtl/core/tprd_out_reg.sv
module tprd_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  tprd_pkg::out_word_t word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tprd_pkg::out_word_t out_word_o
);

  logic                valid_q, valid_d;
  tprd_pkg::out_word_t word_q;

  assign ready_o = !valid_q || out_ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

FILE: rtl/core/touch_report_packet_decoder.sv
// throughput: 1 input word per cycle while out_ready_i does not hold back
// the result register, set by the single decode stage between the input
// register and the result register; a result word passes both registers
// words that give no result are dropped in the decode stage
// reset clears all valid flags, the byte position and the packet state
module touch_report_packet_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tprd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tprd_pkg::out_word_t out_word_o
);

  logic                dec_valid, dec_ready, fire, res_valid;
  tprd_pkg::in_word_t  dec_word;
  tprd_pkg::out_word_t res_word;

  tprd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .valid_o    (dec_valid),
    .ready_i    (dec_ready),
    .word_o     (dec_word)
  );

  assign fire = dec_valid && dec_ready;

  tprd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .word_i      (dec_word),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  tprd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fire && res_valid),
    .ready_o     (dec_ready),
    .word_i      (res_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
